FILE: design/rtss_pkg.sv
// Shared types and codes for the record table search/sort block.
// No dependencies; rtss_alu, the top module and the bench import this package.
package rtss_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_SORT   = 2'd2,
        MODE_CLEAR  = 2'd3
    } rtss_mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } rtss_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SORT_LD0,
        ST_SORT_CARRY,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_END,
        ST_FINISH
    } rtss_state_t;

    typedef enum logic {
        OP_KEY_EQ,
        OP_GRADE_LT
    } rtss_op_t;

    localparam int KEY_W   = 32;
    localparam int GRADE_W = 16;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic signed [GRADE_W-1:0] grade;
    } rtss_rec_t;

    typedef struct packed {
        rtss_op_t  op;
        rtss_rec_t a;
        rtss_rec_t b;
    } rtss_cmp_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [KEY_W-1:0]   record_key;
        logic signed [GRADE_W-1:0] grade_value;
    } rtss_cmd_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [KEY_W-1:0]   found_key;
        logic signed [GRADE_W-1:0] found_grade;
        logic [COUNT_W-1:0]        record_count;
    } rtss_rsp_t;

endpackage

FILE: design/rtss_stream_if.sv
// Valid/ready stream interface, one word per handshake.
// Payload type is a parameter; the block uses rtss_pkg::rtss_cmd_t and rtss_rsp_t.
interface rtss_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/rtss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/rtss_alu.sv
// Shared unit: maps a table position to a RAM address on the circular table,
// and does the one record compare of each step. Uses rtss_pkg.
module rtss_alu
    import rtss_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic [$clog2(MAX_RECORDS)-1:0] head,
    input  logic [$clog2(MAX_RECORDS)-1:0] index,
    output logic [$clog2(MAX_RECORDS)-1:0] phys_addr,
    input  rtss_cmp_t                      cmp,
    output logic                           hit
);

    localparam int ADDR_W = $clog2(MAX_RECORDS);

    logic [ADDR_W:0] sum;

    always_comb
    begin
        sum = {1'b0, head} + {1'b0, index};
        // wrap around the end of the table
        if (sum >= (ADDR_W+1)'(MAX_RECORDS))
        begin
            sum = sum - (ADDR_W+1)'(MAX_RECORDS);
        end
        phys_addr = sum[ADDR_W-1:0];
    end

    always_comb
    begin
        case (cmp.op)
            OP_KEY_EQ:   hit = (cmp.a.key == cmp.b.key);
            OP_GRADE_LT: hit = (cmp.a.grade < cmp.b.grade);
            default:     hit = 1'b0;
        endcase
    end

endmodule

FILE: design/record_table_search_sort_top.sv
// Record table: insert at head, linear search by key, stable bubble sort by grade
// (descending), clear. The table is a circular buffer in one RAM with registered
// read. Insert and clear go from accept straight to the result state. A search
// reads and then compares each record it visits, one after the other. A sort
// runs bubble passes, stopping after a pass with no swap; the single RAM read
// port and the one shared compare unit make each step a read, then a compare.
// No item is taken while one is at work. A finished result sits in an output
// register, and the next command is accepted while it waits. Storage needs no
// clearing pass after reset.
module record_table_search_sort_top
    import rtss_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    rtss_stream_if.sink   cmd,
    rtss_stream_if.source rsp
);

    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int REC_W  = $bits(rtss_rec_t);

    rtss_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    rtss_rsp_t            out_data_reg, out_data_next;

    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic                 swapped_reg, swapped_next;
    rtss_rec_t            carry_reg, carry_next;
    logic signed [KEY_W-1:0]   key_reg, key_next;
    logic [1:0]                status_reg, status_next;
    logic signed [KEY_W-1:0]   fkey_reg, fkey_next;
    logic signed [GRADE_W-1:0] fgrade_reg, fgrade_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    rtss_rec_t            ram_wdata;
    logic [REC_W-1:0]     ram_rdata_raw;
    rtss_rec_t            ram_rdata;

    logic [ADDR_W-1:0]    alu_index;
    logic [ADDR_W-1:0]    phys_addr;
    rtss_cmp_t            cmp;
    logic                 hit;

    logic [ADDR_W-1:0]    head_dec;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    rtss_cmd_t            cmd_word;

    assign ram_rdata = rtss_rec_t'(ram_rdata_raw);
    assign head_dec  = (head_reg == '0) ? ADDR_W'(MAX_RECORDS - 1) : head_reg - 1'b1;
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};
    assign cmd_word  = cmd.payload;

    rtss_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (phys_addr),
        .rdata (ram_rdata_raw)
    );

    rtss_alu #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_alu (
        .head      (head_reg),
        .index     (alu_index),
        .phys_addr (phys_addr),
        .cmp       (cmp),
        .hit       (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        idx_reg      <= idx_next;
        limit_reg    <= limit_next;
        swapped_reg  <= swapped_next;
        carry_reg    <= carry_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        fkey_reg     <= fkey_next;
        fgrade_reg   <= fgrade_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        swapped_next   = swapped_reg;
        carry_next     = carry_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        fkey_next      = fkey_reg;
        fgrade_next    = fgrade_reg;

        ram_we    = 1'b0;
        ram_waddr = phys_addr;
        ram_wdata = carry_reg;
        alu_index = idx_reg;

        cmp.op = OP_GRADE_LT;
        cmp.a  = carry_reg;
        cmp.b  = ram_rdata;

        cmd.ready = (state_reg == ST_IDLE);

        // drop the result word once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next    = cmd_word.record_key;
                    status_next = STATUS_DONE;
                    fkey_next   = '0;
                    fgrade_next = '0;
                    idx_next    = '0;
                    state_next  = ST_FINISH;
                    case (rtss_mode_t'(cmd_word.mode))
                        MODE_INSERT:
                        begin
                            if (count_reg == CNT_W'(MAX_RECORDS))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = head_dec;
                                ram_wdata.key   = cmd_word.record_key;
                                ram_wdata.grade = cmd_word.grade_value;
                                head_next       = head_dec;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        MODE_SORT:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                limit_next = count_reg;
                                state_next = ST_SORT_LD0;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                cmp.op    = OP_KEY_EQ;
                cmp.a.key = key_reg;
                if (hit)
                begin
                    status_next = STATUS_DONE;
                    fkey_next   = ram_rdata.key;
                    fgrade_next = ram_rdata.grade;
                    state_next  = ST_FINISH;
                end
                else if (CNT_W'(idx_reg) == count_reg - 1'b1)
                begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_SORT_LD0:
            begin
                alu_index    = '0;
                idx_next     = '0;
                swapped_next = 1'b0;
                state_next   = ST_SORT_CARRY;
            end

            ST_SORT_CARRY:
            begin
                carry_next = ram_rdata;
                state_next = ST_SORT_RD;
            end

            ST_SORT_RD:
            begin
                alu_index  = idx_reg + 1'b1;
                state_next = ST_SORT_CMP;
            end

            ST_SORT_CMP:
            begin
                // smaller grade rides toward the tail; equal grades stay put
                ram_we = 1'b1;
                if (hit)
                begin
                    ram_wdata    = ram_rdata;
                    swapped_next = 1'b1;
                end
                else
                begin
                    ram_wdata  = carry_reg;
                    carry_next = ram_rdata;
                end
                idx_next = idx_reg + 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(2) == limit_reg)
                begin
                    state_next = ST_SORT_END;
                end
                else
                begin
                    state_next = ST_SORT_RD;
                end
            end

            ST_SORT_END:
            begin
                ram_we     = 1'b1;
                ram_wdata  = carry_reg;
                limit_next = limit_reg - 1'b1;
                if (swapped_reg && limit_reg > CNT_W'(2))
                begin
                    state_next = ST_SORT_LD0;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.found_key    = fkey_reg;
                    out_data_next.found_grade  = fgrade_reg;
                    out_data_next.record_count = count_ext[COUNT_W-1:0];
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp.valid   = out_valid_reg;
        rsp.payload = out_data_reg;
    end

endmodule

FILE: tb/record_table_search_sort_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for record_table_search_sort_top: a directed table, then random
// clear/insert/search/sort episodes checked against an in-bench record table.
// Depends on rtss_pkg, rtss_stream_if and the top module.
module record_table_search_sort_top_test
    import rtss_pkg::*;
();

    localparam int MAX_RECORDS  = 64;
    localparam int RANDOM_WORDS = 2000;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 9;
    localparam int N_DIRECTED   = 25;

    typedef struct {
        rtss_mode_t                mode;
        logic signed [KEY_W-1:0]   key;
        logic signed [GRADE_W-1:0] grade;
        bit                        fixed;
        rtss_status_t              status;
        logic signed [KEY_W-1:0]   found_key;
        logic signed [GRADE_W-1:0] found_grade;
        int                        count;
    } step_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rtss_stream_if #(.payload_t(rtss_cmd_t)) cmd_if ();
    rtss_stream_if #(.payload_t(rtss_rsp_t)) rsp_if ();

    record_table_search_sort_top #(.MAX_RECORDS(MAX_RECORDS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the record table, head at slot 0.
    logic signed [KEY_W-1:0]   table_keys   [MAX_RECORDS];
    logic signed [GRADE_W-1:0] table_grades [MAX_RECORDS];
    int                        table_size = 0;
    rtss_rsp_t                 awaited_results [$];

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned words_sent    = 0;
    int unsigned sorts_run     = 0;
    int unsigned full_rejects  = 0;
    int unsigned search_hits   = 0;
    int unsigned search_misses = 0;
    int unsigned cycle_count   = 0;
    bit          calm          = 1'b0;
    bit          hold_request  = 1'b0;

    step_row_t directed_rows [N_DIRECTED] = '{
        '{MODE_SEARCH, 32'h0000_0000, 16'h0000, 1'b1, STATUS_NOT_FOUND, 32'h0, 16'h0, 0},
        '{MODE_SORT,   32'h0000_0000, 16'h0000, 1'b1, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, STATUS_DONE, 32'h0, 16'h0, 1},
        '{MODE_SORT,   32'h0000_0000, 16'h0000, 1'b1, STATUS_DONE, 32'h0, 16'h0, 1},
        '{MODE_INSERT, 32'h8000_0000, 16'h8000, 1'b1, STATUS_DONE, 32'h0, 16'h0, 2},
        '{MODE_SEARCH, 32'h7FFF_FFFF, 16'h0000, 1'b1, STATUS_DONE, 32'h7FFF_FFFF, 16'h7FFF, 2},
        '{MODE_SEARCH, 32'h8000_0000, 16'h1234, 1'b1, STATUS_DONE, 32'h8000_0000, 16'h8000, 2},
        '{MODE_INSERT, 32'h0000_0000, 16'h0000, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'd5,         16'd100,  1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'd5,         16'd200,  1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'd9,         16'd200,  1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'd5,         16'h0000, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'd0,         16'hFFFF, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'd1234,      16'h0000, 1'b1, STATUS_NOT_FOUND, 32'h0, 16'h0, 7},
        '{MODE_SORT,   32'hAAAA_5555, 16'h5555, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'd5,         16'h0000, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'hFFFF_FFFF, 16'h0000, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'd1,         16'hFF38, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SORT,   32'h5555_AAAA, 16'hAAAA, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'd1,         16'h0000, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_CLEAR,  32'd7,         16'd7,    1'b1, STATUS_DONE, 32'h0, 16'h0, 0},
        '{MODE_SEARCH, 32'd5,         16'h0000, 1'b1, STATUS_NOT_FOUND, 32'h0, 16'h0, 0},
        '{MODE_INSERT, 32'd5,         16'd3,    1'b1, STATUS_DONE, 32'h0, 16'h0, 1},
        '{MODE_SEARCH, 32'd5,         16'h0000, 1'b0, STATUS_DONE, 32'h0, 16'h0, 0}
    };

    // Apply one command to the shadow table and return the result it must produce.
    function automatic rtss_rsp_t apply_command(input rtss_cmd_t c);
        rtss_rsp_t                 r;
        logic signed [KEY_W-1:0]   k;
        logic signed [GRADE_W-1:0] g;
        int                        i;
        int                        bound;
        bit                        swapped;
        r = '0;
        r.status = STATUS_DONE;
        case (rtss_mode_t'(c.mode))
            MODE_INSERT:
            begin
                if (table_size >= MAX_RECORDS)
                begin
                    r.status = STATUS_FULL;
                    full_rejects++;
                end
                else
                begin
                    for (i = table_size; i > 0; i--)
                    begin
                        table_keys[i]   = table_keys[i-1];
                        table_grades[i] = table_grades[i-1];
                    end
                    table_keys[0]   = c.record_key;
                    table_grades[0] = c.grade_value;
                    table_size++;
                end
            end
            MODE_SEARCH:
            begin
                r.status = STATUS_NOT_FOUND;
                for (i = 0; i < table_size; i++)
                begin
                    if (table_keys[i] == c.record_key)
                    begin
                        r.status      = STATUS_DONE;
                        r.found_key   = table_keys[i];
                        r.found_grade = table_grades[i];
                        break;
                    end
                end
                if (r.status == STATUS_DONE)
                    search_hits++;
                else
                    search_misses++;
            end
            MODE_SORT:
            begin
                // Bubble passes, highest grade first; equal grades never swap.
                bound   = table_size;
                swapped = 1'b1;
                while (swapped && bound > 1)
                begin
                    swapped = 1'b0;
                    for (i = 0; i + 1 < bound; i++)
                    begin
                        if (table_grades[i] < table_grades[i+1])
                        begin
                            k                 = table_keys[i];
                            g                 = table_grades[i];
                            table_keys[i]     = table_keys[i+1];
                            table_grades[i]   = table_grades[i+1];
                            table_keys[i+1]   = k;
                            table_grades[i+1] = g;
                            swapped           = 1'b1;
                        end
                    end
                    bound--;
                end
                sorts_run++;
            end
            default:
            begin
                table_size = 0;
            end
        endcase
        r.record_count = COUNT_W'(table_size);
        return r;
    endfunction

    function automatic rtss_cmd_t make_cmd(input rtss_mode_t mode,
                                           input logic [KEY_W-1:0] key,
                                           input logic [GRADE_W-1:0] grade);
        rtss_cmd_t c;
        c.mode        = mode;
        c.record_key  = key;
        c.grade_value = grade;
        return c;
    endfunction

    // Small pools make duplicate keys and tied grades common.
    function automatic logic [KEY_W-1:0] insert_key();
        if ($urandom_range(0, 99) < 40)
            return KEY_W'($urandom_range(0, 7));
        return $urandom;
    endfunction

    function automatic logic [GRADE_W-1:0] insert_grade();
        logic [GRADE_W-1:0] g;
        if ($urandom_range(0, 99) < 40)
        begin
            g = GRADE_W'($urandom_range(0, 4));
            return g - GRADE_W'(2);
        end
        return GRADE_W'($urandom);
    endfunction

    function automatic logic [KEY_W-1:0] search_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (table_size > 0 && pick < 70)
            return table_keys[$urandom_range(0, table_size - 1)];
        if (pick < 85)
            return insert_key();
        return $urandom;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] result %0d: %s got %0h, want %0h", $time, results_seen, what,
                     got, want);
    endtask

    task automatic check_result(input rtss_rsp_t got);
        rtss_rsp_t want;
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            flag_mismatch("unexpected word, status", 32'(got.status), 32'h0);
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.found_key !== want.found_key)
            flag_mismatch("found_key", got.found_key, want.found_key);
        if (got.found_grade !== want.found_grade)
            flag_mismatch("found_grade", 32'(got.found_grade), 32'(want.found_grade));
        if (got.record_count !== want.record_count)
            flag_mismatch("record_count", 32'(got.record_count), 32'(want.record_count));
    endtask

    // Offer one word, hold it until accepted, then predict its result.
    task automatic send_word(input rtss_cmd_t w, input bit use_fixed = 1'b0,
                             input rtss_rsp_t fixed = '0);
        int        gap;
        rtss_rsp_t predicted;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= w;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        predicted = apply_command(w);
        awaited_results.push_back(use_fixed ? fixed : predicted);
        words_sent++;
    endtask

    task automatic run_episode(input bit big);
        int target;
        int ops;
        int pick;
        target = big ? MAX_RECORDS : $urandom_range(0, 12);
        send_word(make_cmd(MODE_CLEAR, $urandom, GRADE_W'($urandom)));
        ops = big ? MAX_RECORDS + 40 : target + $urandom_range(3, 12);
        repeat (ops)
        begin
            pick = $urandom_range(0, 99);
            if (table_size < target && pick < (big ? 85 : 55))
                send_word(make_cmd(MODE_INSERT, insert_key(), insert_grade()));
            else if (pick < 80)
                send_word(make_cmd(MODE_SEARCH, search_key(), GRADE_W'($urandom)));
            else if (pick < (big ? 82 : 92))
                send_word(make_cmd(MODE_SORT, $urandom, GRADE_W'($urandom)));
            else if (pick < 97)
                send_word(make_cmd(MODE_INSERT, insert_key(), insert_grade()));
            else
                send_word(make_cmd(rtss_mode_t'(2'($urandom_range(0, 3))), $urandom,
                                   GRADE_W'($urandom)));
        end
        if (big)
        begin
            // Top up to full, then hit the full-table reject and a full sort.
            while (table_size < MAX_RECORDS)
                send_word(make_cmd(MODE_INSERT, insert_key(), insert_grade()));
            send_word(make_cmd(MODE_INSERT, insert_key(), insert_grade()));
            send_word(make_cmd(MODE_SORT, $urandom, GRADE_W'($urandom)));
            send_word(make_cmd(MODE_SEARCH, table_keys[MAX_RECORDS-1], 16'h0));
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
                     awaited_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : result_sink
        int hold_left;
        hold_left    = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                check_result(rsp_if.payload);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        rtss_rsp_t fixed_rsp;
        int        random_words;
        bit        hold_done;
        hold_done      = 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[n])
        begin
            fixed_rsp.status       = directed_rows[n].status;
            fixed_rsp.found_key    = directed_rows[n].found_key;
            fixed_rsp.found_grade  = directed_rows[n].found_grade;
            fixed_rsp.record_count = COUNT_W'(directed_rows[n].count);
            send_word(make_cmd(directed_rows[n].mode, directed_rows[n].key,
                               directed_rows[n].grade),
                      directed_rows[n].fixed, fixed_rsp);
        end

        run_episode(1'b1);
        random_words = words_sent - N_DIRECTED;
        while (random_words < RANDOM_WORDS)
        begin
            calm = (random_words >= 800 && random_words < 1100);
            // One long stall on the result side while commands keep coming.
            if (!hold_done && random_words >= 300)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            run_episode($urandom_range(0, 29) == 0);
            random_words = words_sent - N_DIRECTED;
        end
        calm = 1'b0;
        cmd_if.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d words (%0d directed), checked %0d results, %0d mismatches",
                 words_sent, N_DIRECTED, results_seen, mismatches);
        $display("sorts %0d, full-table rejects %0d, search hits %0d, misses %0d",
                 sorts_run, full_rejects, search_hits, search_misses);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/rtss_pkg.sv
design/rtss_stream_if.sv
design/rtss_ram.sv
design/rtss_alu.sv
design/record_table_search_sort_top.sv
tb/record_table_search_sort_top_test.sv
